// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Field widths, operation and status codes, and the microprogram of the
// sequencer that runs each request.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam int OP_W       = 2;
	localparam int POS_W      = 11;
	localparam int VAL_W      = 8;
	localparam int ST_W       = 2;
	localparam int S_TDATA_W  = 24;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 40;
	localparam int UPC_W      = 4;

	// request kinds
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
	localparam logic [OP_W-1:0] OP_GET    = 2'd3;

	// result status
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

	typedef logic [UPC_W-1:0] upc_t;

	// microprogram step addresses
	localparam upc_t S_IDLE      = 4'd0;
	localparam upc_t S_CHECK     = 4'd1;
	localparam upc_t S_INS_SETUP = 4'd2;
	localparam upc_t S_INS_MOVE  = 4'd3;
	localparam upc_t S_INS_PUT   = 4'd4;
	localparam upc_t S_RD_POS    = 4'd5;
	localparam upc_t S_LATCH     = 4'd6;
	localparam upc_t S_DEL_MOVE  = 4'd7;
	localparam upc_t S_DEL_FIN   = 4'd8;
	localparam upc_t S_LOC_SETUP = 4'd9;
	localparam upc_t S_LOC_SCAN  = 4'd10;
	localparam upc_t S_EMIT      = 4'd11;

	typedef enum logic [2:0] {
		SQ_NEXT,
		SQ_JUMP,
		SQ_WAIT_IN,
		SQ_DISPATCH,
		SQ_LOOP,
		SQ_SCAN,
		SQ_GET,
		SQ_EMIT
	} seq_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_INS,
		LD_POS,
		LD_LOC
	} ld_t;

	typedef enum logic [1:0] {
		MV_NONE,
		MV_DOWN,
		MV_UP,
		MV_SCAN
	} mv_t;

	typedef enum logic [1:0] {
		LEN_HOLD,
		LEN_INC,
		LEN_DEC
	} len_t;

	typedef struct packed {
		seq_t seq;
		logic take;
		logic check;
		ld_t  ld;
		mv_t  mv;
		logic put;
		len_t len;
		logic latch;
		logic emit;
		upc_t target;
	} cw_t;

	typedef struct packed {
		logic            in_valid;
		logic            out_free;
		logic            err;
		logic            cnt_zero;
		logic            scan_end;
		logic [OP_W-1:0] op;
	} cond_t;

	function automatic cw_t ucode(input upc_t a);
		cw_t w;
		w = '0;
		unique case (a)
			S_IDLE: begin
				w.take = 1'b1;
				w.seq  = SQ_WAIT_IN;
			end
			S_CHECK: begin
				w.check  = 1'b1;
				w.seq    = SQ_DISPATCH;
				w.target = S_EMIT;
			end
			S_INS_SETUP: begin
				w.ld  = LD_INS;
				w.seq = SQ_NEXT;
			end
			S_INS_MOVE: begin
				w.mv     = MV_DOWN;
				w.seq    = SQ_LOOP;
				w.target = S_INS_PUT;
			end
			S_INS_PUT: begin
				w.put    = 1'b1;
				w.len    = LEN_INC;
				w.seq    = SQ_JUMP;
				w.target = S_EMIT;
			end
			S_RD_POS: begin
				w.ld  = LD_POS;
				w.seq = SQ_NEXT;
			end
			S_LATCH: begin
				w.latch  = 1'b1;
				w.seq    = SQ_GET;
				w.target = S_EMIT;
			end
			S_DEL_MOVE: begin
				w.mv     = MV_UP;
				w.seq    = SQ_LOOP;
				w.target = S_DEL_FIN;
			end
			S_DEL_FIN: begin
				w.len    = LEN_DEC;
				w.seq    = SQ_JUMP;
				w.target = S_EMIT;
			end
			S_LOC_SETUP: begin
				w.ld  = LD_LOC;
				w.seq = SQ_NEXT;
			end
			S_LOC_SCAN: begin
				w.mv     = MV_SCAN;
				w.seq    = SQ_SCAN;
				w.target = S_EMIT;
			end
			S_EMIT: begin
				w.emit   = 1'b1;
				w.seq    = SQ_EMIT;
				w.target = S_IDLE;
			end
			default: begin
				w.seq    = SQ_JUMP;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: sv/ple_seq.sv
// ----------------------------------------------------------------------------
// Positional list engine sequencer
// Step counter over the microprogram; fetches one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_seq
	import ple_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cond_t cond,
	output cw_t        cw
);

	upc_t upc_q;
	upc_t upc_next;

	assign cw = ucode(upc_q);

	always_comb begin
		upc_next = upc_q + upc_t'(1);
		unique case (cw.seq)
			SQ_NEXT: upc_next = upc_q + upc_t'(1);
			SQ_JUMP: upc_next = cw.target;
			SQ_WAIT_IN: begin
				upc_next = cond.in_valid ? upc_q + upc_t'(1) : upc_q;
			end
			SQ_DISPATCH: begin
				if (cond.err) begin
					upc_next = cw.target;
				end else begin
					unique case (cond.op) inside
						OP_INSERT:        upc_next = S_INS_SETUP;
						OP_LOCATE:        upc_next = S_LOC_SETUP;
						OP_DELETE, OP_GET: upc_next = S_RD_POS;
						default:          upc_next = S_IDLE;
					endcase
				end
			end
			SQ_LOOP: upc_next = cond.cnt_zero ? cw.target : upc_q;
			SQ_SCAN: upc_next = cond.scan_end ? cw.target : upc_q;
			SQ_GET: begin
				upc_next = (cond.op == OP_GET) ? cw.target : upc_q + upc_t'(1);
			end
			SQ_EMIT: upc_next = cond.out_free ? cw.target : upc_q;
			default: upc_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

endmodule

`default_nettype wire

// File: sv/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered byte list in a single-port-write memory with a length count;
// insert, delete and locate run as microprogrammed element walks; get reads.
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (low bit up)                          tuser
// s_*       in   position[10:0], value[18:11], pad to 24     op[1:0]
// m_*       out  status[1:0], data_out[9:2],                 -
//                found_position[20:10], count[31:21],
//                is_empty[32], pad to 40
//
// One request is in flight at a time. A rejected request goes from the
// check straight to the output register; get reads one element, insert
// and delete shift the tail of the list from the position, and locate
// compares from the first element on. The walks move or compare one element
// per cycle, bound by the single read and single write port of the element memory.
// The result sits in an output register, so the next request is accepted
// while a result waits on m_tready. arst_n clears the length and the
// sequencer; the element memory is not cleared, as only entries below the
// length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_top
	import ple_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // position, value
	input  wire logic [S_TUSER_W-1:0] s_tuser,  // op
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [M_TDATA_W-1:0] m_tdata   // status, data_out, found_position,
	                                            // count, is_empty
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int NW = ((LW > POS_W) ? LW : POS_W) + 1;

	cw_t   cw;
	cond_t cond;

	// request registers
	logic [OP_W-1:0]  op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;

	// list state and walk pointers
	logic [LW-1:0]    len_q;
	logic [AW-1:0]    ptr_q;
	logic [LW-1:0]    cnt_q;
	logic [AW-1:0]    wa_q;
	logic             pend_q;

	// element memory
	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;
	logic             mem_re;
	logic             mem_we;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;

	// result registers
	logic [ST_W-1:0]      status_q;
	logic [VAL_W-1:0]     data_q;
	logic [POS_W-1:0]     found_q;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_q;

	logic [NW-1:0]    len_n;
	logic [NW-1:0]    pos_n;
	logic [NW-1:0]    pidx_n;
	logic [NW-1:0]    ins_ptr_n;
	logic [NW-1:0]    ins_cnt_n;
	logic [NW-1:0]    del_ptr_n;
	logic [NW-1:0]    del_cnt_n;
	logic [NW-1:0]    found_n;
	logic [ST_W-1:0]  chk_status;
	logic             chk_err;
	logic             cnt_zero;
	logic             hit;
	logic             scan_end;
	logic             walking;
	logic             shifting;
	logic             out_free;
	logic             out_load;
	logic             in_take;

	ple_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.cw     (cw)
	);

	assign len_n     = NW'(len_q);
	assign pos_n     = NW'(pos_q);
	assign pidx_n    = pos_n - NW'(1);
	assign ins_ptr_n = len_n - NW'(1);
	assign ins_cnt_n = len_n - pidx_n;
	assign del_ptr_n = pidx_n + NW'(1);
	assign del_cnt_n = len_n - del_ptr_n;
	assign found_n   = NW'(wa_q) + NW'(1);

	assign cnt_zero = (cnt_q == '0);
	assign hit      = pend_q && (rdata_q == val_q);
	assign scan_end = hit || (!pend_q && cnt_zero);
	assign walking  = (cw.mv != MV_NONE);
	assign shifting = (cw.mv == MV_DOWN) || (cw.mv == MV_UP);

	assign out_free = !out_valid_q || m_tready;
	assign out_load = cw.emit && out_free;

	assign s_tready = cw.take;
	assign in_take  = s_tvalid && cw.take;

	assign cond.in_valid = s_tvalid;
	assign cond.out_free = out_free;
	assign cond.err      = chk_err;
	assign cond.cnt_zero = cnt_zero;
	assign cond.scan_end = scan_end;
	assign cond.op       = op_q;

	// Screen the request: fullness before position for insert, emptiness
	// before position for delete and get. Locate is always walked.
	always_comb begin
		chk_status = ST_OK;
		unique case (op_q) inside
			OP_INSERT: begin
				if (len_n >= NW'(CAPACITY)) begin
					chk_status = ST_FULL;
				end else if ((pos_q == '0) || (pos_n > len_n + NW'(1))) begin
					chk_status = ST_BADPOS;
				end
			end
			OP_DELETE, OP_GET: begin
				if (len_q == '0) begin
					chk_status = ST_EMPTY;
				end else if ((pos_q == '0) || (pos_n > len_n)) begin
					chk_status = ST_BADPOS;
				end
			end
			default: chk_status = ST_OK;
		endcase
		chk_err = (chk_status != ST_OK);
	end

	// Memory ports: a position read on setup, or a walk read; the write is
	// either the lagging shift write or the final placement of an insert.
	always_comb begin
		mem_re = (cw.ld == LD_POS) || (walking && !cnt_zero);
		raddr  = (cw.ld == LD_POS) ? pidx_n[AW-1:0] : ptr_q;
		mem_we = cw.put || (shifting && pend_q);
		waddr  = cw.put ? pidx_n[AW-1:0] : wa_q;
		wdata  = cw.put ? val_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Hold the request while it runs.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q  <= s_tuser[OP_W-1:0];
			pos_q <= s_tdata[POS_W-1:0];
			val_q <= s_tdata[POS_W+VAL_W-1:POS_W];
		end
	end

	// Walk pointers: load on setup, advance one element per walk cycle.
	always_ff @(posedge clk) begin
		case (cw.ld)
			LD_INS: begin
				ptr_q <= ins_ptr_n[AW-1:0];
				cnt_q <= ins_cnt_n[LW-1:0];
			end
			LD_POS: begin
				ptr_q <= del_ptr_n[AW-1:0];
				cnt_q <= del_cnt_n[LW-1:0];
			end
			LD_LOC: begin
				ptr_q <= '0;
				cnt_q <= len_q;
			end
			default: begin
				if (walking && !cnt_zero) begin
					cnt_q <= cnt_q - LW'(1);
					case (cw.mv)
						MV_DOWN: begin
							wa_q  <= ptr_q + AW'(1);
							ptr_q <= ptr_q - AW'(1);
						end
						MV_UP: begin
							wa_q  <= ptr_q - AW'(1);
							ptr_q <= ptr_q + AW'(1);
						end
						default: begin
							wa_q  <= ptr_q;
							ptr_q <= ptr_q + AW'(1);
						end
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			len_q  <= '0;
		end else begin
			if (cw.ld != LD_NONE) begin
				pend_q <= 1'b0;
			end else if (walking) begin
				pend_q <= !cnt_zero;
			end
			case (cw.len)
				LEN_INC: len_q <= len_q + LW'(1);
				LEN_DEC: len_q <= len_q - LW'(1);
				default: len_q <= len_q;
			endcase
		end
	end

	// Result fields.
	always_ff @(posedge clk) begin
		if (cw.check) begin
			status_q <= chk_status;
			data_q   <= '0;
			found_q  <= '0;
		end
		if (cw.latch) begin
			data_q <= rdata_q;
		end
		if (cw.mv == MV_SCAN) begin
			if (hit) begin
				found_q <= found_n[POS_W-1:0];
			end else if (scan_end) begin
				status_q <= ST_EMPTY;
			end
		end
	end

	// Output register: load when free or being drained in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {7'b0, (len_q == '0), len_n[POS_W-1:0], found_q, data_q, status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Sends insert, delete, locate and get transactions to the list engine with
// random idling on both stream sides. A local copy of the list predicts every
// result, and each result transaction is checked in order against it.
// ----------------------------------------------------------------------------

module testbench;
	import ple_pkg::*;

	localparam int LIST_CAPACITY    = 1024;
	localparam int RANDOM_ITEMS     = 500;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES      = 64;
	localparam int MAX_REPORTS      = 10;
	// Longest quiet stretch of a correct run: a locate over a full list
	// plus the long receiver hold plus a long sender gap.
	// Allow many times that before calling the run hung.
	localparam int STALL_LIMIT      = 20000;

	// One result transaction, unpacked into its fields
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] data;
		logic [POS_W-1:0] found;
		logic [POS_W-1:0] count;
		logic             empty;
	} list_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // position[10:0], value[18:11], zero pad
	logic [S_TUSER_W-1:0] s_tuser  = '0;  // op[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // status[1:0], data_out[9:2],
	                                      // found_position[20:10], count[31:21],
	                                      // is_empty[32], zero pad

	// Predicted list contents and length, plus results still to arrive
	logic [VAL_W-1:0] list_mem [LIST_CAPACITY];
	int               list_len = 0;
	list_result_t     pending_results[$];
	list_result_t     seen_result;
	list_result_t     due_result;

	int error_count   = 0;
	int stall_cycles  = 0;
	// Receiver pacing: a long hold is requested by bumping hold_requests
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int sink_gap      = 0;
	bit src_steady    = 1'b0;
	bit sink_steady   = 1'b0;

	positional_list_engine_top #(
		.CAPACITY(LIST_CAPACITY)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Byte to store or search: half from a small alphabet so duplicates occur
	function automatic logic [VAL_W-1:0] rand_value();
		if ($urandom_range(0, 1)) return VAL_W'($urandom_range(0, 255));
		return VAL_W'($urandom_range(0, 7));
	endfunction

	// Position of an existing element, or 1 on an empty list
	function automatic logic [POS_W-1:0] pick_member_position();
		if (list_len == 0) return POS_W'(1);
		return POS_W'($urandom_range(1, list_len));
	endfunction

	// Apply one request to the local list and return the result it must give
	function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_result_t r;
		int           p;
		int           k;
		r        = '0;
		r.status = ST_OK;
		p        = int'(pos);
		case (op)
			OP_INSERT: begin
				// fullness wins over a bad position
				if (list_len >= LIST_CAPACITY) begin
					r.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ST_BADPOS;
				end else begin
					for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k - 1];
					list_mem[p - 1] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					r.data = list_mem[p - 1];
					for (k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
					list_len--;
				end
			end
			OP_LOCATE: begin
				// no match, or an empty list, reports not found at position 0
				r.status = ST_EMPTY;
				for (k = 0; k < list_len && r.found == '0; k++) begin
					if (list_mem[k] == val) begin
						r.status = ST_OK;
						r.found  = POS_W'(k + 1);
					end
				end
			end
			default: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					r.data = list_mem[p - 1];
				end
			end
		endcase
		r.count = POS_W'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("%s", msg);
	endtask

	// Offer one request, hold it until the transaction completes, then predict.
	// Valid stays high into the next request unless a gap is taken, so it
	// never gets two assignments in one step.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= S_TDATA_W'($urandom);
			s_tuser  <= S_TUSER_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - POS_W - VAL_W){1'b0}}, val, pos};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(list_apply(op, pos, val));
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Every operation on an empty list, and inserts at bad positions
	task automatic test_empty_list();
		send_request(OP_DELETE, 11'd1, 8'h00);
		send_request(OP_GET, 11'd0, 8'h00);
		send_request(OP_LOCATE, 11'd0, 8'hFF);
		send_request(OP_INSERT, 11'd0, 8'h11);
		send_request(OP_INSERT, 11'd2, 8'h22);
		send_request(OP_INSERT, 11'd2047, 8'h33);
		wait_drained();
	endtask

	// Short directed run through each operation and its edge positions
	task automatic test_single_ops();
		send_request(OP_INSERT, 11'd1, 8'h00);
		send_request(OP_INSERT, 11'd2, 8'hFF);
		send_request(OP_INSERT, 11'd1, 8'hA5);
		send_request(OP_INSERT, 11'd3, 8'h5A);
		send_request(OP_INSERT, 11'd6, 8'h77);    // one past length+1
		send_request(OP_GET, 11'd1, 8'h00);
		send_request(OP_GET, 11'd4, 8'h00);
		send_request(OP_GET, 11'd5, 8'h00);       // one past length
		send_request(OP_GET, 11'd0, 8'h00);
		send_request(OP_LOCATE, 11'd0, 8'hFF);
		send_request(OP_LOCATE, 11'd2047, 8'h5A);
		send_request(OP_INSERT, 11'd5, 8'hA5);    // append a duplicate
		send_request(OP_LOCATE, 11'd0, 8'hA5);    // first match wins
		send_request(OP_LOCATE, 11'd0, 8'h33);    // no match
		send_request(OP_DELETE, 11'd0, 8'h00);
		send_request(OP_DELETE, 11'd6, 8'h00);    // length+1 is rejected
		send_request(OP_DELETE, 11'd2, 8'h00);
		send_request(OP_DELETE, 11'd1, 8'h00);
		send_request(OP_DELETE, 11'd3, 8'h00);    // last element
		send_request(OP_GET, 11'd2047, 8'h00);
		wait_drained();
	endtask

	// Hold the receiver off for a long stretch while requests keep coming, so
	// the output register fills and the input stalls; then pause the sender
	// until every result is back.
	task automatic test_input_stall();
		int n;
		src_steady = 1'b1;
		hold_requests++;
		for (n = 0; n < 12; n++) begin
			if (n % 3 == 0) begin
				send_request(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)), rand_value());
			end else if (n % 3 == 1) begin
				send_request(OP_GET, pick_member_position(), 8'h00);
			end else begin
				send_request(OP_LOCATE, POS_W'($urandom), rand_value());
			end
		end
		src_steady = 1'b0;
		wait_drained();
	endtask

	// Mostly well-formed requests on a list kept short, with some noise
	task automatic test_random_mix();
		int              n;
		int              roll;
		int              ins_w;
		int              del_w;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// change pacing every hundred items, with some stretches unpaced
			if (n % 100 == 0) begin
				src_steady  = ($urandom_range(0, 3) == 0);
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			val = rand_value();
			if ($urandom_range(0, 99) < 15) begin
				op  = OP_W'($urandom);
				pos = POS_W'($urandom);
			end else begin
				// steer the length between a few and a few dozen elements
				ins_w = (list_len < 8) ? 50 : (list_len > 48) ? 10 : 30;
				del_w = (list_len < 8) ? 10 : (list_len > 48) ? 50 : 30;
				roll  = $urandom_range(0, ins_w + del_w + 39);
				if (roll < ins_w) begin
					op  = OP_INSERT;
					pos = POS_W'($urandom_range(1, list_len + 1));
				end else if (roll < ins_w + del_w) begin
					op  = OP_DELETE;
					pos = pick_member_position();
				end else if (roll < ins_w + del_w + 20) begin
					op  = OP_GET;
					pos = pick_member_position();
				end else begin
					op  = OP_LOCATE;
					pos = POS_W'($urandom);
					if (list_len > 0 && $urandom_range(0, 1))
						val = list_mem[$urandom_range(0, list_len - 1)];
				end
			end
			send_request(op, pos, val);
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		wait_drained();
	endtask

	// Fill the list to capacity and probe the full list and its longest walks
	task automatic test_capacity_limit();
		int n;
		// empty it first so the fill values are known
		while (list_len > 0) send_request(OP_DELETE, POS_W'(list_len), rand_value());
		// fill with bytes below 8'hFE; a few inserts land inside the list
		n = 0;
		while (list_len < LIST_CAPACITY - 1) begin
			if (n % 97 == 50) begin
				send_request(OP_INSERT, POS_W'($urandom_range(1, list_len + 1)),
					VAL_W'($urandom_range(0, 253)));
			end else begin
				send_request(OP_INSERT, POS_W'(list_len + 1), VAL_W'($urandom_range(0, 253)));
			end
			n++;
		end
		send_request(OP_INSERT, 11'd1024, 8'hFE);
		send_request(OP_INSERT, 11'd1, 8'h00);     // full list
		send_request(OP_INSERT, 11'd0, 8'h00);     // full reported before position
		send_request(OP_INSERT, 11'd2047, 8'h00);
		send_request(OP_GET, 11'd1024, 8'h00);
		send_request(OP_GET, 11'd1025, 8'h00);
		send_request(OP_LOCATE, 11'd0, 8'hFE);     // match at the last position
		send_request(OP_LOCATE, 11'd0, 8'hFF);     // full scan, no match
		send_request(OP_DELETE, 11'd0, 8'h00);
		send_request(OP_DELETE, 11'd1025, 8'h00);
		send_request(OP_DELETE, 11'd1024, 8'h00);
		send_request(OP_DELETE, 11'd1, 8'h00);     // longest shift down
		send_request(OP_INSERT, 11'd1, 8'hFF);     // longest shift up
		send_request(OP_LOCATE, 11'd0, 8'hFF);     // match at the first position
		wait_drained();
	endtask

	// Result side: check each result transaction, then choose next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen_result.status = m_tdata[1:0];
				seen_result.data   = m_tdata[9:2];
				seen_result.found  = m_tdata[20:10];
				seen_result.count  = m_tdata[31:21];
				seen_result.empty  = m_tdata[32];
				if (pending_results.size() == 0) begin
					report_error($sformatf("unexpected result transaction %h", m_tdata));
				end else begin
					due_result = pending_results.pop_front();
					if (seen_result !== due_result) begin
						report_error($sformatf({"result mismatch: expected status %0d data %02h",
							" found %0d count %0d empty %0b, got status %0d data %02h",
							" found %0d count %0d empty %0b"},
							due_result.status, due_result.data, due_result.found,
							due_result.count, due_result.empty,
							seen_result.status, seen_result.data, seen_result.found,
							seen_result.count, seen_result.empty));
					end
				end
			end
			// start a long hold when one is requested
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				sink_gap = pick_gap();
				if (sink_gap == 0) begin
					m_tready <= 1'b1;
				end else begin
					sink_gap--;
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Sequence: reset once, run each test, drain, then report
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_single_ops();
		test_input_stall();
		test_random_mix();
		test_capacity_limit();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_error($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
